// ===== src/ttc_pkg.sv =====
// Shared types, constants and key packing for the tile tag cache.
package ttc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;
  localparam int COL_W             = 17;
  localparam int ZOOM_W            = 5;
  localparam int KEY_W             = 2 * COL_W + 2 * ZOOM_W;
  localparam int HANDLE_W          = 16;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic                func;
    logic [COL_W-1:0]    tile_col;
    logic [COL_W-1:0]    tile_row;
    logic [ZOOM_W-1:0]   zoom;
    logic [ZOOM_W-1:0]   source;
    logic [HANDLE_W-1:0] handle_in;
  } in_word_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Key layout: source, zoom, row, col from msb down.
  function automatic logic [KEY_W-1:0] pack_key(input in_word_t w);
    return {w.source, w.zoom, w.tile_row, w.tile_col};
  endfunction

endpackage

// ===== src/tile_tag_cache_fifo.sv =====
// Tile tag cache: fully associative tag store with FIFO replacement.
//
// Input channel in_valid/in_ready/in_data carries one request word: a
// lookup (func 0) or an insert (func 1) of a tile key with its handle.
// Output channel out_valid/out_ready/out_data returns exactly one result
// word per request: hit and handle for a lookup, the evicted handle for an
// insert.
// Keys and handles live in one synchronous memory of CACHE_ENTRIES words,
// read one entry a cycle; valid bits sit in flip-flops.
// A lookup walks the memory from entry 0 and stops at the first valid
// match, or after the last entry on a miss; the next request is taken
// in the cycle after the result is loaded.
// An insert reads the victim, writes the new entry and advances the
// round-robin pointer; it too ends before the next request is taken.
// The scan over the single memory read port sets the lookup rate.
// Reset clears all valid bits and the pointer; no clearing pass is needed.
// The output register holds a result while out_ready is low; the next
// request is still accepted and runs, and it waits only to load its result.
module tile_tag_cache_fifo
  import ttc_pkg::*;
#(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int               IDX_W    = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0]         key_r;
  logic [HANDLE_W-1:0]      handle_r;
  out_word_t                result_r, result_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_data_r;

  entry_t                   mem [CACHE_ENTRIES];
  entry_t                   rd_q;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic                     accept;
  logic                     load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mem_we    = (state_r == ST_INS);

  // Prefetch the next entry while comparing the current one.
  always_comb begin
    if (state_r == ST_SCAN) begin
      rd_addr = cmp_idx_r + 1'b1;
    end else if (in_data.func == FUNC_INSERT) begin
      rd_addr = ptr_r;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= '{key: key_r, handle: handle_r};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cmp_idx_nxt   = cmp_idx_r;
    ptr_nxt       = ptr_r;
    valid_nxt     = valid_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmp_idx_nxt = '0;
          result_nxt  = '0;
          state_nxt   = (in_data.func == FUNC_INSERT) ? ST_INS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (valid_r[cmp_idx_r] && (rd_q.key == key_r)) begin
          result_nxt.hit        = 1'b1;
          result_nxt.handle_out = rd_q.handle;
          state_nxt             = ST_DONE;
        end else if (cmp_idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end
      ST_INS: begin
        if (valid_r[ptr_r]) begin
          result_nxt.evicted_valid  = 1'b1;
          result_nxt.evicted_handle = rd_q.handle;
        end
        valid_nxt[ptr_r] = 1'b1;
        ptr_nxt          = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        state_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_idx_r   <= '0;
      ptr_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      ptr_r       <= ptr_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= pack_key(in_data);
      handle_r <= in_data.handle_in;
    end
    result_r <= result_nxt;
    if (load_out) begin
      out_data_r <= result_r;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cmp_idx_r <= LAST_IDX))
    else $error("scan index beyond last entry");

  a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=>
      (ptr_r == (($past(ptr_r) == LAST_IDX) ? '0 : $past(ptr_r) + 1'b1)))
    else $error("insert pointer did not advance");

  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> valid_r[$past(ptr_r)])
    else $error("inserted slot not marked valid");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.handle_out == '0))
    else $error("handle on miss or insert is not zero");

  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted_valid))
    else $error("hit and eviction in one result");

endmodule

// ===== tb/tile_tag_cache_fifo_tb.sv =====
// Self-checking testbench for the tile tag cache with round-robin replacement.
module tile_tag_cache_fifo_tb
  import ttc_pkg::*;
();

  localparam int ENTRIES     = CACHE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_REQS = 1275;

  class tile_cache_scoreboard;
    logic [KEY_W-1:0]    slot_key    [ENTRIES];
    logic [HANDLE_W-1:0] slot_handle [ENTRIES];
    bit                  slot_live   [ENTRIES];
    int unsigned         fill_ptr;
    out_word_t           awaited_results[$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         hits_predicted;
    int unsigned         evictions_predicted;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]    = '0;
        slot_handle[i] = '0;
        slot_live[i]   = 1'b0;
      end
      fill_ptr            = 0;
      mismatches          = 0;
      results_seen        = 0;
      hits_predicted      = 0;
      evictions_predicted = 0;
    endfunction

    function logic [KEY_W-1:0] pack_tile_key(in_word_t w);
      return {w.source, w.zoom, w.tile_row, w.tile_col};
    endfunction

    // Work out the result of one accepted request and update the tag store.
    function void note_request(in_word_t w);
      out_word_t        want;
      logic [KEY_W-1:0] k;
      bit               found;
      want  = '0;
      found = 1'b0;
      k     = pack_tile_key(w);
      if (w.func == FUNC_LOOKUP) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && slot_live[i] && slot_key[i] == k) begin
            found           = 1'b1;
            want.hit        = 1'b1;
            want.handle_out = slot_handle[i];
          end
        end
        if (found) hits_predicted++;
      end else begin
        if (slot_live[fill_ptr]) begin
          want.evicted_valid  = 1'b1;
          want.evicted_handle = slot_handle[fill_ptr];
          evictions_predicted++;
        end
        slot_key[fill_ptr]    = k;
        slot_handle[fill_ptr] = w.handle_in;
        slot_live[fill_ptr]   = 1'b1;
        fill_ptr              = (fill_ptr + 1) % ENTRIES;
      end
      awaited_results.push_back(want);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing awaited: %h", got);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        mismatches++;
      end
      if (got.handle_out !== want.handle_out) begin
        $error("handle_out: expected %h, got %h", want.handle_out, got.handle_out);
        mismatches++;
      end
      if (got.evicted_valid !== want.evicted_valid) begin
        $error("evicted_valid: expected %0d, got %0d", want.evicted_valid, got.evicted_valid);
        mismatches++;
      end
      if (got.evicted_handle !== want.evicted_handle) begin
        $error("evicted_handle: expected %h, got %h", want.evicted_handle,
               got.evicted_handle);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  tile_tag_cache_fifo #(.CACHE_ENTRIES(ENTRIES)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  tile_cache_scoreboard sb = new();
  bit          no_idle;
  int unsigned cycle_count;
  int unsigned lookups_sent;
  int unsigned inserts_sent;
  in_word_t    key_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic in_word_t make_word(logic fn, logic [KEY_W-1:0] k,
                                         logic [HANDLE_W-1:0] h);
    in_word_t w;
    w.func = fn;
    {w.source, w.zoom, w.tile_row, w.tile_col} = k;
    w.handle_in = h;
    return w;
  endfunction

  function automatic logic [COL_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COL_W'($urandom_range(0, (1 << COL_W) - 1));
    endcase
  endfunction

  // Zoom mostly in its usual range, now and then beyond it.
  function automatic logic [KEY_W-1:0] random_key();
    logic [ZOOM_W-1:0] zm;
    logic [ZOOM_W-1:0] src;
    zm  = ($urandom_range(0, 9) < 7) ? ZOOM_W'($urandom_range(0, 17))
                                     : ZOOM_W'($urandom_range(0, 31));
    src = ZOOM_W'($urandom_range(0, 31));
    return {src, zm, pick_coord(), pick_coord()};
  endfunction

  // Caller is at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    sb.note_request(w);
    if (w.func == FUNC_INSERT) begin
      inserts_sent++;
      key_pool.push_back(w);
      if (key_pool.size() > 24) void'(key_pool.pop_front());
    end else begin
      lookups_sent++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: draw a stall per word, then take it when it shows up.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin
    logic [KEY_W-1:0] key_zero;
    logic [KEY_W-1:0] key_ones;
    logic [KEY_W-1:0] k;
    in_word_t         w;
    int               pick;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    no_idle      = 1'b0;
    cycle_count  = 0;
    lookups_sent = 0;
    inserts_sent = 0;
    key_zero     = '0;
    key_ones     = '1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty cache: both extreme keys miss.
    send_word(make_word(FUNC_LOOKUP, key_zero, 16'hFFFF));
    send_word(make_word(FUNC_LOOKUP, key_ones, 16'h0000));
    // Inserts into empty slots evict nothing.
    send_word(make_word(FUNC_INSERT, key_zero, 16'hFFFF));
    send_word(make_word(FUNC_INSERT, key_ones, 16'h0000));
    send_word(make_word(FUNC_LOOKUP, key_zero, 16'h5A5A));
    send_word(make_word(FUNC_LOOKUP, key_ones, 16'hA5A5));
    // Duplicate key: lookup must still return the lower slot.
    send_word(make_word(FUNC_INSERT, key_zero, 16'h1234));
    send_word(make_word(FUNC_LOOKUP, key_zero, 16'h0000));
    // Near misses: zoom beyond its range, lowest column bit, top source bit.
    k = key_zero;
    k[KEY_W-ZOOM_W +: ZOOM_W] = '0;
    k[2*COL_W +: ZOOM_W]      = ZOOM_W'(20);
    send_word(make_word(FUNC_LOOKUP, k, 16'h0001));
    send_word(make_word(FUNC_LOOKUP, key_zero ^ KEY_W'(1), 16'h0002));
    send_word(make_word(FUNC_LOOKUP, key_ones ^ (KEY_W'(1) << (KEY_W - 1)), 16'h0003));
    // Fill the rest, then wrap: the next insert evicts slot 0.
    for (int i = 3; i < ENTRIES; i++)
      send_word(make_word(FUNC_INSERT, random_key(), HANDLE_W'($urandom_range(0, 65535))));
    send_word(make_word(FUNC_INSERT, random_key(), 16'hBEEF));
    send_word(make_word(FUNC_LOOKUP, key_zero, 16'h0000));
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 250 == 125) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Mostly fresh keys, sometimes a copy of a recently inserted one.
        if (pick < 5 && key_pool.size() != 0)
          k = sb.pack_tile_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else
          k = random_key();
        w = make_word(FUNC_INSERT, k, HANDLE_W'($urandom_range(0, 65535)));
      end else begin
        if (pick < 76 && key_pool.size() != 0)
          k = sb.pack_tile_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else if (pick < 88 && key_pool.size() != 0)
          k = sb.pack_tile_key(key_pool[$urandom_range(0, key_pool.size() - 1)])
              ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
        else
          k = random_key();
        w = make_word(FUNC_LOOKUP, k, HANDLE_W'($urandom_range(0, 65535)));
      end
      send_word(w);
    end

    wait_drained();
    repeat (2 * ENTRIES + 8) @(posedge clk);
    $display("sent %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
             lookups_sent, sb.hits_predicted, inserts_sent, sb.evictions_predicted);
    $display("checked %0d result words, %0d field mismatches",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
